// ===== design/tnopr_pkg.sv =====
// Shared types, byte codes and reply tables for the telnet option parser/responder.
// Used by every module in this folder; no dependencies of its own.
package tnopr_pkg;

	localparam logic [7:0] IAC = 8'hFF;
	localparam logic [7:0] SE  = 8'd240;
	localparam logic [7:0] NOP = 8'd241;
	localparam logic [7:0] GA  = 8'd249;
	localparam logic [7:0] SB  = 8'd250;
	localparam logic [7:0] WILL = 8'd251;
	localparam logic [7:0] WONT = 8'd252;
	localparam logic [7:0] DO  = 8'd253;
	localparam logic [7:0] DONT = 8'd254;

	localparam logic [7:0] OPT_BINARY = 8'd0;
	localparam logic [7:0] OPT_ECHO   = 8'd1;
	localparam logic [7:0] OPT_TTYPE  = 8'd24;
	localparam logic [7:0] OPT_NAWS   = 8'd31;

	// configuration register indexes
	localparam logic [1:0] CFG_ANSI_MODE   = 2'd0;
	localparam logic [1:0] CFG_NARROW      = 2'd1;
	localparam logic [1:0] CFG_AUTO_DL     = 2'd2;
	localparam int CFG_DATA_W = 1;

	// job queue between parser and reply generator; depth is a power of two
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_CMD     = 4'b0010,
		PH_SUB     = 4'b0100,
		PH_SUB_IAC = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		JOB_DISPLAY,
		JOB_SEND3,
		JOB_NAWS,
		JOB_TT_ANSI,
		JOB_TT_UNKNOWN
	} job_kind_t;

	// a: display byte, verb or width; b: option or height
	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] a;
		logic [7:0] b;
		logic       echo;
		logic       start;
	} job_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       enter_hit;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_dest;
		logic       last_of_run;
		logic       local_echo;
		logic       start_download;
	} res_t;

	// index of the final byte of a job
	function automatic logic [3:0] job_last(input job_kind_t kind);
		case (kind)
			JOB_DISPLAY:    job_last = 4'd0;
			JOB_SEND3:      job_last = 4'd2;
			JOB_NAWS:       job_last = 4'd8;
			JOB_TT_ANSI:    job_last = 4'd9;
			JOB_TT_UNKNOWN: job_last = 4'd12;
			default:        job_last = 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] job_byte(input job_t job, input logic [3:0] idx);
		logic [7:0] r;
		r = SE;
		case (job.kind)
			JOB_DISPLAY: r = job.a;
			JOB_SEND3: begin
				case (idx)
					4'd0:    r = IAC;
					4'd1:    r = job.a;
					default: r = job.b;
				endcase
			end
			JOB_NAWS: begin
				case (idx)
					4'd0:    r = IAC;
					4'd1:    r = SB;
					4'd2:    r = OPT_NAWS;
					4'd3:    r = 8'd0;
					4'd4:    r = job.a;
					4'd5:    r = 8'd0;
					4'd6:    r = job.b;
					4'd7:    r = IAC;
					default: r = SE;
				endcase
			end
			JOB_TT_ANSI: begin
				case (idx)
					4'd0:    r = IAC;
					4'd1:    r = SB;
					4'd2:    r = OPT_TTYPE;
					4'd3:    r = 8'd0;
					4'd4:    r = 8'h41; // A
					4'd5:    r = 8'h4E; // N
					4'd6:    r = 8'h53; // S
					4'd7:    r = 8'h49; // I
					4'd8:    r = IAC;
					default: r = SE;
				endcase
			end
			JOB_TT_UNKNOWN: begin
				case (idx)
					4'd0:    r = IAC;
					4'd1:    r = SB;
					4'd2:    r = OPT_TTYPE;
					4'd3:    r = 8'd0;
					4'd4:    r = 8'h55; // U
					4'd5:    r = 8'h4E; // N
					4'd6:    r = 8'h4B; // K
					4'd7:    r = 8'h4E; // N
					4'd8:    r = 8'h4F; // O
					4'd9:    r = 8'h57; // W
					4'd10:   r = 8'h4E; // N
					4'd11:   r = IAC;
					default: r = SE;
				endcase
			end
			default: r = SE;
		endcase
		return r;
	endfunction

endpackage

// ===== design/tnopr_front.sv =====
// Front end: telnet receive parser, option state and configuration registers.
// Turns each accepted byte into at most one reply job. Depends on tnopr_pkg.
module tnopr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  tnopr_pkg::req_t                   request,
	input  logic                              cfg_wen,
	input  logic [1:0]                        cfg_index,
	input  logic [tnopr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                              job_valid,
	output tnopr_pkg::job_t                   job
);
	import tnopr_pkg::*;

	phase_t     phase_q, phase_d;
	logic [1:0] pos_q, pos_d;
	logic [7:0] verb_q, verb_d;
	logic [7:0] opt_q, opt_d;
	logic       echo_q, echo_d;
	logic       supp_q, supp_d;
	logic       ansi_q, narrow_q, auto_q;

	logic       do_resp;
	logic [7:0] resp_opt;
	logic       start;
	logic [7:0] b;

	assign b = request.rx_byte;

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		verb_d    = verb_q;
		opt_d     = opt_q;
		echo_d    = echo_q;
		supp_d    = supp_q;
		do_resp   = 1'b0;
		resp_opt  = opt_q;
		start     = 1'b0;
		job_valid = 1'b0;
		job       = '0;
		job.kind  = JOB_DISPLAY;

		case (phase_q)
			PH_IDLE: begin
				if (b == IAC) begin
					phase_d = PH_CMD;
					pos_d   = 2'd1;
				end else begin
					job_valid = 1'b1;
					job.a     = b;
				end
			end
			PH_CMD: begin
				if (pos_q == 2'd1) begin
					if (b == IAC) begin
						phase_d   = PH_IDLE;
						job_valid = 1'b1;
						job.a     = IAC;
					end else if (b inside {[NOP:GA]}) begin
						phase_d = PH_IDLE;
					end else begin
						verb_d = b;
						pos_d  = 2'd2;
						if (b == SB)
							phase_d = PH_SUB;
					end
				end else begin
					opt_d    = b;
					pos_d    = 2'd3;
					phase_d  = PH_IDLE;
					do_resp  = 1'b1;
					resp_opt = b;
				end
			end
			PH_SUB: begin
				// first byte after SB is the option, even if it is IAC
				if (pos_q == 2'd2) begin
					opt_d = b;
					pos_d = 2'd3;
				end
				if (b == IAC)
					phase_d = PH_SUB_IAC;
			end
			PH_SUB_IAC: begin
				if (b == SE) begin
					phase_d = PH_IDLE;
					do_resp = 1'b1;
				end else begin
					phase_d = PH_SUB;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		if (do_resp) begin
			case (verb_q)
				DO: begin
					job_valid = 1'b1;
					if (resp_opt == OPT_NAWS) begin
						job.kind = JOB_NAWS;
						job.a    = (ansi_q || !narrow_q) ? 8'd80 : 8'd40;
						job.b    = ansi_q ? 8'd25 : 8'd24;
					end else begin
						job.kind = JOB_SEND3;
						job.a    = (resp_opt == OPT_TTYPE || resp_opt == OPT_BINARY) ? WILL : WONT;
						job.b    = resp_opt;
					end
				end
				WILL: begin
					job_valid = 1'b1;
					job.kind  = JOB_SEND3;
					job.a     = DO;
					job.b     = resp_opt;
					if (resp_opt == OPT_ECHO)
						echo_d = 1'b0;
					if (resp_opt == OPT_BINARY) begin
						if (!request.enter_hit)
							supp_d = 1'b1;
						else if (auto_q && !supp_q)
							start = 1'b1;
					end
				end
				SB: begin
					if (resp_opt == OPT_TTYPE) begin
						job_valid = 1'b1;
						job.kind  = ansi_q ? JOB_TT_ANSI : JOB_TT_UNKNOWN;
					end
				end
				WONT: begin
					job_valid = 1'b1;
					job.kind  = JOB_SEND3;
					job.a     = DONT;
					job.b     = resp_opt;
					if (resp_opt == OPT_ECHO)
						echo_d = 1'b1;
				end
				DONT: begin
					job_valid = 1'b1;
					job.kind  = JOB_SEND3;
					job.a     = WONT;
					job.b     = resp_opt;
				end
				default: ;
			endcase
		end

		job.echo  = echo_d;
		job.start = start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= 2'd0;
			verb_q  <= 8'd0;
			opt_q   <= 8'd0;
			echo_q  <= 1'b1;
			supp_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			verb_q  <= verb_d;
			opt_q   <= opt_d;
			echo_q  <= echo_d;
			supp_q  <= supp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ansi_q   <= 1'b1;
			narrow_q <= 1'b0;
			auto_q   <= 1'b1;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_ANSI_MODE: ansi_q   <= cfg_data[0];
				CFG_NARROW:    narrow_q <= cfg_data[0];
				CFG_AUTO_DL:   auto_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/tnopr_jobq.sv =====
// Small register queue of reply jobs between the parser and the reply generator.
// Depth set by JOBQ_DEPTH in tnopr_pkg.
module tnopr_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  tnopr_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output logic            avail,
	output tnopr_pkg::job_t rd_job
);
	import tnopr_pkg::*;

	job_t                  slot_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOBQ_CNT_W-1:0] count_q;
	logic                  do_wr, do_rd;

	assign full   = (count_q == JOBQ_CNT_W'(JOBQ_DEPTH));
	assign avail  = (count_q != '0);
	assign rd_job = slot_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && avail;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/tnopr_back.sv =====
// Back end: expands one job into its result bytes into an output register, one per cycle
// while it is free or popped. Depends on tnopr_pkg for job_t, res_t and the reply tables.
module tnopr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_avail,
	input  tnopr_pkg::job_t job_in,
	output logic            job_take,
	input  logic            pop,
	output logic            empty,
	output tnopr_pkg::res_t result
);
	import tnopr_pkg::*;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	res_t       out_q;
	logic       out_ready, emit, is_last;
	res_t       next_res;

	assign out_ready = !out_valid_q || pop;
	assign is_last   = (idx_q == job_last(cur_q.kind));
	assign emit      = cur_valid_q && out_ready;
	// refill while the current job hands out its final byte
	assign job_take  = job_avail && (!cur_valid_q || (emit && is_last));

	always_comb begin
		next_res.out_byte       = job_byte(cur_q, idx_q);
		next_res.out_dest       = (cur_q.kind != JOB_DISPLAY);
		next_res.last_of_run    = is_last;
		next_res.local_echo     = cur_q.echo;
		next_res.start_download = cur_q.start;
	end

	always_ff @(posedge clk) begin
		if (job_take)
			cur_q <= job_in;
		if (emit)
			out_q <= next_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end else if (emit) begin
				if (is_last)
					cur_valid_q <= 1'b0;
				else
					idx_q <= idx_q + 4'd1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== design/telnet_option_parser_responder_unit.sv =====
// Telnet receive parser and option responder, top level.
// Jobs pass the job queue, current-job and output registers. Throughput: one request
// per cycle while the 4-job queue has room; the reply generator sends one result per
// cycle unless pop stalls it (up to 13 for one request), so long replies hold the queue.
// Reset (arst_n low, asynchronous): parser idle, echo on, queues empty, config at defaults.
module telnet_option_parser_responder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// request side
	input  logic                              push,
	input  tnopr_pkg::req_t                   request,
	output logic                              full,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output tnopr_pkg::res_t                   result,
	// configuration writes
	input  logic                              cfg_wen,
	input  logic [1:0]                        cfg_index,
	input  logic [tnopr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tnopr_pkg::*;

	logic accept;
	logic front_job_valid;
	job_t front_job;
	logic q_full, q_avail, q_take;
	job_t q_job;

	// A request is taken whenever the job queue has a free slot; it does not
	// matter whether the request produces a job, so full is only queue state.
	assign full   = q_full;
	assign accept = push && !q_full;

	// parser: phase, command position, verb/option, echo and suppression state
	tnopr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.request   (request),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (front_job_valid),
		.job       (front_job)
	);

	// decouples byte parsing from multi-byte reply generation
	tnopr_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && front_job_valid),
		.wr_job (front_job),
		.full   (q_full),
		.rd_en  (q_take),
		.avail  (q_avail),
		.rd_job (q_job)
	);

	// reply generator and output register
	tnopr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (q_avail),
		.job_in    (q_job),
		.job_take  (q_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
